// File: hdl/fbl_pkg.sv
// shared types and constants of the fat12 boot file locator
`timescale 1ns / 1ps

package fbl_pkg;

    localparam logic [63:0] NAME_CONST    = 64'h2020202020204F49;
    localparam logic [23:0] EXT_CONST     = 24'h535953;
    localparam logic [31:0] FIRST_CLUSTER = 32'd2;
    localparam logic [7:0]  FILE_SECTORS  = 8'd3;
    localparam logic [5:0]  SECTOR_BASE   = 6'd1;

    localparam int CFG_DW  = 16;
    localparam int CFG_IW  = 3;
    localparam int PCYL_W  = 22;

    typedef enum logic [CFG_IW-1:0] {
        CFG_RESERVED = 3'd0,
        CFG_COPIES   = 3'd1,
        CFG_SPT_TBL  = 3'd2,
        CFG_ROOT_ENT = 3'd3,
        CFG_SEC_BYTE = 3'd4,
        CFG_CLUS_SEC = 3'd5,
        CFG_HEADS    = 3'd6,
        CFG_TRK_SEC  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        op;
        logic        match;
        logic [24:0] root_lba;
        logic [31:0] file_part;
    } div1_pay_t;

    typedef struct packed {
        logic        op;
        logic        match;
        logic [31:0] lba;
        logic [7:0]  count;
    } div2_pay_t;

    typedef struct packed {
        logic        op;
        logic        match;
        logic [31:0] lba;
        logic [7:0]  count;
        logic [7:0]  cyl;
    } div3_pay_t;

endpackage

// File: hdl/fbl_if.sv
// valid/ready channel interfaces for directory entry items and located results
`timescale 1ns / 1ps

interface fbl_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] name_bytes;
    logic [23:0] extension_bytes;
    logic [15:0] start_cluster;

    modport source (output valid, opcode, name_bytes, extension_bytes, start_cluster,
                    input ready);
    modport sink   (input valid, opcode, name_bytes, extension_bytes, start_cluster,
                    output ready);
endinterface

interface fbl_out_if;
    logic        valid;
    logic        ready;
    logic        name_match;
    logic [31:0] block_address;
    logic [7:0]  cylinder_low;
    logic [7:0]  head_number;
    logic [5:0]  sector_number;
    logic [7:0]  sector_count;

    modport source (output valid, name_match, block_address, cylinder_low, head_number,
                    sector_number, sector_count, input ready);
    modport sink   (input valid, name_match, block_address, cylinder_low, head_number,
                    sector_number, sector_count, output ready);
endinterface

// File: hdl/fbl_div.sv
// pipelined restoring divider, one quotient bit per stage, payload carried alongside
`timescale 1ns / 1ps

module fbl_div #(
    parameter int DW = 32,
    parameter int VW = 16,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem,
    output logic [PW-1:0] out_pay
);

    logic          v_reg [DW];
    logic [VW-1:0] r_reg [DW];
    logic [DW-1:0] x_reg [DW];
    logic [PW-1:0] p_reg [DW];

    genvar k;
    for (k = 0; k < DW; k++)
    begin : g_stage
        logic          v_src;
        logic [VW-1:0] r_src;
        logic [DW-1:0] x_src;
        logic [PW-1:0] p_src;
        logic [VW:0]   t;
        logic [VW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_src = in_valid;
            assign r_src = '0;
            assign x_src = dividend;
            assign p_src = in_pay;
        end
        else
        begin : g_next
            assign v_src = v_reg[k-1];
            assign r_src = r_reg[k-1];
            assign x_src = x_reg[k-1];
            assign p_src = p_reg[k-1];
        end

        assign t    = {r_src, x_src[DW-1]};
        assign diff = t - {1'b0, divisor};
        assign ge   = (t >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? diff[VW-1:0] : t[VW-1:0];
                x_reg[k] <= {x_src[DW-2:0], ge};
                p_reg[k] <= p_src;
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign quot      = x_reg[DW-1];
    assign rem       = r_reg[DW-1];
    assign out_pay   = p_reg[DW-1];

endmodule

// File: hdl/fat12_boot_file_locator_top.sv
// top level: fat12 root directory and boot file locator with chs translation
//
// items enter on the item channel (valid/ready); each beat gives exactly one
// beat on the result channel, in order. opcode 0 asks for the root directory
// location and size, opcode 1 checks one directory entry name against the
// boot file name and locates that file when it matches.
// geometry sits in eight registers written through cfg_we/cfg_index/cfg_data;
// write them only while no item is in flight.
// the pipeline is three address stages, a 21-stage divider for the root
// size, one select stage, a 32-stage divider for the cylinder, a 22-stage
// divider for head and sector, and the output register.
// throughput is one item per cycle unless the receiver stalls, as the dividers are pipelined.
// reset clears all valid bits and loads the default 1.44 MB floppy geometry.
// when the receiver stalls a full output register, the whole pipeline holds;
// bubbles never block the item channel since ready drops only then.
`timescale 1ns / 1ps

module fat12_boot_file_locator_top
    import fbl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fbl_in_if.sink            item,
    fbl_out_if.source         result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic [15:0] reserved_reg;
    logic [7:0]  copies_reg;
    logic [15:0] spt_tbl_reg;
    logic [15:0] root_ent_reg;
    logic [15:0] sec_bytes_reg;
    logic [7:0]  clus_sec_reg;
    logic [15:0] heads_reg;
    logic [5:0]  trk_sec_reg;
    logic [PCYL_W-1:0] per_cyl_reg;

    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= 16'd1;
            copies_reg    <= 8'd2;
            spt_tbl_reg   <= 16'd9;
            root_ent_reg  <= 16'd224;
            sec_bytes_reg <= 16'd512;
            clus_sec_reg  <= 8'd1;
            heads_reg     <= 16'd2;
            trk_sec_reg   <= 6'd18;
            per_cyl_reg   <= PCYL_W'(36);
        end
        else
        begin
            // products are used far down the pipe, so registering them here is harmless
            per_cyl_reg <= heads_reg * trk_sec_reg;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RESERVED: reserved_reg  <= cfg_data;
                    CFG_COPIES:   copies_reg    <= cfg_data[7:0];
                    CFG_SPT_TBL:  spt_tbl_reg   <= cfg_data;
                    CFG_ROOT_ENT: root_ent_reg  <= cfg_data;
                    CFG_SEC_BYTE: sec_bytes_reg <= cfg_data;
                    CFG_CLUS_SEC: clus_sec_reg  <= cfg_data[7:0];
                    CFG_HEADS:    heads_reg     <= cfg_data;
                    CFG_TRK_SEC:  trk_sec_reg   <= cfg_data[5:0];
                    default:      ;
                endcase
            end
        end
    end

    // stage 1: products and name compare
    logic        s1_v_reg, s1_op_reg, s1_match_reg;
    logic [23:0] s1_prod_reg;
    logic [31:0] s1_offs_reg;
    // stage 2: root lba
    logic        s2_v_reg, s2_op_reg, s2_match_reg;
    logic [24:0] s2_a_reg;
    logic [31:0] s2_offs_reg;
    // stage 3: root lba plus cluster offset
    logic        s3_v_reg, s3_op_reg, s3_match_reg;
    logic [24:0] s3_a_reg;
    logic [31:0] s3_ao_reg;
    // stage 4: lba select
    logic        s4_v_reg;
    div2_pay_t   s4_pay_reg;
    // output register
    logic        s5_v_reg;
    logic        s5_match_reg;
    logic [31:0] s5_lba_reg;
    logic [7:0]  s5_cyl_reg;
    logic [7:0]  s5_head_reg;
    logic [5:0]  s5_sec_reg;
    logic [7:0]  s5_count_reg;

    assign en         = !s5_v_reg || result.ready;
    assign item.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= item.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg    <= item.opcode;
            s1_match_reg <= (item.name_bytes == NAME_CONST) &&
                            (item.extension_bytes == EXT_CONST);
            s1_prod_reg  <= copies_reg * spt_tbl_reg;
            s1_offs_reg  <= (32'(item.start_cluster) - FIRST_CLUSTER) * 32'(clus_sec_reg);

            s2_op_reg    <= s1_op_reg;
            s2_match_reg <= s1_match_reg;
            s2_a_reg     <= 25'(reserved_reg) + 25'(s1_prod_reg);
            s2_offs_reg  <= s1_offs_reg;

            s3_op_reg    <= s2_op_reg;
            s3_match_reg <= s2_match_reg;
            s3_a_reg     <= s2_a_reg;
            s3_ao_reg    <= 32'(s2_a_reg) + s2_offs_reg;
        end
    end

    // root size = entries*32 / sector bytes
    div1_pay_t   d1_in, d1_out;
    logic        d1_v;
    logic [20:0] d1_q;
    logic [15:0] d1_r;

    assign d1_in = '{op: s3_op_reg, match: s3_match_reg, root_lba: s3_a_reg,
                     file_part: s3_ao_reg};

    fbl_div #(.DW(21), .VW(16), .PW($bits(div1_pay_t))) u_div_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .dividend  ({root_ent_reg, 5'b0}),
        .divisor   (sec_bytes_reg),
        .in_pay    (d1_in),
        .out_valid (d1_v),
        .quot      (d1_q),
        .rem       (d1_r),
        .out_pay   (d1_out)
    );

    logic [7:0] rsize;
    assign rsize = (sec_bytes_reg == 16'd0) ? 8'd0 : d1_q[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= d1_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pay_reg.op    <= d1_out.op;
            s4_pay_reg.match <= d1_out.match;
            s4_pay_reg.lba   <= d1_out.op ? (d1_out.file_part + 32'(rsize))
                                          : 32'(d1_out.root_lba);
            s4_pay_reg.count <= d1_out.op ? FILE_SECTORS : rsize;
        end
    end

    // cylinder = lba / (heads*spt)
    div2_pay_t         d2_out;
    div3_pay_t         d3_in, d3_out;
    logic              d2_v, d3_v;
    logic [31:0]       d2_q;
    logic [PCYL_W-1:0] d2_r;
    logic [PCYL_W-1:0] d3_q;
    logic [5:0]        d3_r;

    fbl_div #(.DW(32), .VW(PCYL_W), .PW($bits(div2_pay_t))) u_div_cyl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .dividend  (s4_pay_reg.lba),
        .divisor   (per_cyl_reg),
        .in_pay    (s4_pay_reg),
        .out_valid (d2_v),
        .quot      (d2_q),
        .rem       (d2_r),
        .out_pay   (d2_out)
    );

    assign d3_in = '{op: d2_out.op, match: d2_out.match, lba: d2_out.lba,
                     count: d2_out.count, cyl: d2_q[7:0]};

    // head and sector from the remainder within the cylinder
    fbl_div #(.DW(PCYL_W), .VW(6), .PW($bits(div3_pay_t))) u_div_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_v),
        .dividend  (d2_r),
        .divisor   (trk_sec_reg),
        .in_pay    (d3_in),
        .out_valid (d3_v),
        .quot      (d3_q),
        .rem       (d3_r),
        .out_pay   (d3_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (en)
            s5_v_reg <= d3_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d3_out.op && !d3_out.match)
            begin
                s5_match_reg <= 1'b0;
                s5_lba_reg   <= '0;
                s5_cyl_reg   <= '0;
                s5_head_reg  <= '0;
                s5_sec_reg   <= '0;
                s5_count_reg <= '0;
            end
            else
            begin
                s5_match_reg <= d3_out.op;
                s5_lba_reg   <= d3_out.lba;
                s5_count_reg <= d3_out.count;
                if (per_cyl_reg == '0)
                begin
                    s5_cyl_reg  <= '0;
                    s5_head_reg <= '0;
                    s5_sec_reg  <= SECTOR_BASE;
                end
                else
                begin
                    s5_cyl_reg  <= d3_out.cyl;
                    s5_head_reg <= d3_q[7:0];
                    s5_sec_reg  <= d3_r + SECTOR_BASE;
                end
            end
        end
    end

    assign result.valid         = s5_v_reg;
    assign result.name_match    = s5_match_reg;
    assign result.block_address = s5_lba_reg;
    assign result.cylinder_low  = s5_cyl_reg;
    assign result.head_number   = s5_head_reg;
    assign result.sector_number = s5_sec_reg;
    assign result.sector_count  = s5_count_reg;

    a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.name_match) |-> (result.sector_count == FILE_SECTORS))
        else $error("matched entry without file sector count");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> s1_v_reg)
        else $error("accepted beat missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && !en) |=> s1_v_reg)
        else $error("first stage lost its beat during stall");

endmodule
